// ===== rtl/tpsb_pkg.sv =====
package tpsb_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 2;

    localparam logic [CfgIndexW-1:0] CFG_TEXTURED       = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_RAW_TEXTURE    = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_SEMI_ENABLE    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_SEMI_MODE      = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_DITHER_REQUEST = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_GOURAUD_SHADED = 3'd5;

    localparam logic [1:0] BLEND_AVERAGE = 2'd0;
    localparam logic [1:0] BLEND_ADD     = 2'd1;
    localparam logic [1:0] BLEND_SUB     = 2'd2;
    localparam logic [1:0] BLEND_QUARTER = 2'd3;

    // 4x4 ordered dither offsets, entry {y, x} in nibble y*4+x, two's complement
    localparam logic [63:0] DITHER_TABLE = 64'hE2F3_0C1D_F3E2_1D0C;

    localparam logic [4:0] CHAN_MAX = 5'd31;
    localparam logic [7:0] BYTE_MAX = 8'd255;

    typedef enum logic [1:0] {
        KIND_TRANSPARENT,
        KIND_RAW,
        KIND_SHADE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       textured;
        logic       raw;
        logic       dither;
        logic       blend;
        logic [1:0] semi_mode;
        logic       stp;
    } ctrl_t;

    typedef struct packed {
        ctrl_t              ctrl;
        logic signed [3:0]  offset;
        logic [15:0]        texel;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [14:0]        background;
    } item_t;

endpackage

// ===== rtl/tpsb_front.sv =====
module tpsb_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpsb_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [tpsb_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     pixel_x_low,
    input  logic [1:0]                     pixel_y_low,
    input  logic [15:0]                    texel,
    input  logic [7:0]                     color_red,
    input  logic [7:0]                     color_green,
    input  logic [7:0]                     color_blue,
    input  logic [15:0]                    background_pixel,
    input  logic                           queue_full,
    output logic                           push,
    output tpsb_pkg::item_t                item
);

    logic       textured_reg;
    logic       raw_texture_reg;
    logic       semi_enable_reg;
    logic [1:0] semi_mode_reg;
    logic       dither_request_reg;
    logic       gouraud_shaded_reg;
    logic [3:0] dither_index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            textured_reg       <= 1'b0;
            raw_texture_reg    <= 1'b0;
            semi_enable_reg    <= 1'b0;
            semi_mode_reg      <= 2'd0;
            dither_request_reg <= 1'b0;
            gouraud_shaded_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tpsb_pkg::CFG_TEXTURED:       textured_reg       <= cfg_data[0];
                tpsb_pkg::CFG_RAW_TEXTURE:    raw_texture_reg    <= cfg_data[0];
                tpsb_pkg::CFG_SEMI_ENABLE:    semi_enable_reg    <= cfg_data[0];
                tpsb_pkg::CFG_SEMI_MODE:      semi_mode_reg      <= cfg_data[1:0];
                tpsb_pkg::CFG_DITHER_REQUEST: dither_request_reg <= cfg_data[0];
                tpsb_pkg::CFG_GOURAUD_SHADED: gouraud_shaded_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    assign in_stall     = queue_full;
    assign push         = in_valid && !queue_full;
    assign dither_index = {pixel_y_low, pixel_x_low};

    always_comb
    begin
        item.offset     = $signed(tpsb_pkg::DITHER_TABLE[{dither_index, 2'b00} +: 4]);
        item.texel      = texel;
        item.red        = color_red;
        item.green      = color_green;
        item.blue       = color_blue;
        item.background = background_pixel[14:0];

        item.ctrl.textured  = textured_reg;
        item.ctrl.raw       = raw_texture_reg;
        item.ctrl.semi_mode = semi_mode_reg;
        item.ctrl.stp       = textured_reg && texel[15];
        if (textured_reg)
        begin
            item.ctrl.dither = dither_request_reg && !raw_texture_reg;
            item.ctrl.blend  = semi_enable_reg && texel[15];
        end
        else
        begin
            item.ctrl.dither = dither_request_reg && gouraud_shaded_reg;
            item.ctrl.blend  = semi_enable_reg;
        end

        if (textured_reg && (texel == 16'd0))
            item.ctrl.kind = tpsb_pkg::KIND_TRANSPARENT;
        else if (textured_reg && raw_texture_reg && !semi_enable_reg)
            item.ctrl.kind = tpsb_pkg::KIND_RAW;
        else
            item.ctrl.kind = tpsb_pkg::KIND_SHADE;
    end

endmodule

// ===== rtl/tpsb_queue.sv =====
module tpsb_queue
#(
    parameter int Depth = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpsb_pkg::item_t push_item,
    input  logic            pop,
    output tpsb_pkg::item_t pop_item,
    output logic            full,
    output logic            empty
);

    localparam int PtrW   = $clog2(Depth);
    localparam int CountW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0]   LastPtr  = PtrW'(Depth - 1);
    localparam logic [CountW-1:0] FullCount = CountW'(Depth);

    tpsb_pkg::item_t   entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;

    assign full     = (count_reg == FullCount);
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FullCount)
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== rtl/tpsb_back.sv =====
module tpsb_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  tpsb_pkg::item_t item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            write_enable,
    output logic [15:0]     pixel_value
);

    logic        out_valid_reg;
    logic        write_enable_reg;
    logic        write_enable_next;
    logic [15:0] pixel_value_reg;
    logic [15:0] pixel_value_next;
    logic [4:0]  fg_red;
    logic [4:0]  fg_green;
    logic [4:0]  fg_blue;
    logic [14:0] fg_pixel;
    logic [14:0] blended;

    function automatic logic [4:0] shade_channel(
        input logic [4:0]        t5,
        input logic [7:0]        c8,
        input logic signed [3:0] d,
        input tpsb_pkg::ctrl_t   c
    );
        logic [12:0]       prod;
        logic [5:0]        mod5_wide;
        logic [4:0]        mod5;
        logic [8:0]        mod8_wide;
        logic [7:0]        base8;
        logic signed [9:0] dsum;
        logic [7:0]        dclamp;
        logic [4:0]        result;
        prod      = 13'(t5) * 13'(c8);
        mod5_wide = prod[12:7];
        mod5      = (mod5_wide > 6'(tpsb_pkg::CHAN_MAX)) ? tpsb_pkg::CHAN_MAX : mod5_wide[4:0];
        mod8_wide = prod[12:4];
        base8     = mod8_wide[8] ? tpsb_pkg::BYTE_MAX : mod8_wide[7:0];
        if (!c.textured)
            base8 = c8;
        dsum = $signed({2'b00, base8}) + 10'(d);
        if (dsum < 0)
            dclamp = 8'd0;
        else if (dsum > $signed(10'(tpsb_pkg::BYTE_MAX)))
            dclamp = tpsb_pkg::BYTE_MAX;
        else
            dclamp = dsum[7:0];
        if (c.textured && c.raw)
            result = t5;
        else if (c.dither)
            result = dclamp[7:3];
        else if (c.textured)
            result = mod5;
        else
            result = c8[7:3];
        return result;
    endfunction

    function automatic logic [4:0] blend_channel(
        input logic [4:0] b5,
        input logic [4:0] f5,
        input logic [1:0] mode
    );
        logic [5:0]        avg;
        logic signed [6:0] s;
        logic [4:0]        result;
        avg = {1'b0, b5} + {1'b0, f5};
        case (mode)
            tpsb_pkg::BLEND_AVERAGE: s = $signed({2'b00, avg[5:1]});
            tpsb_pkg::BLEND_ADD:     s = $signed({2'b00, b5}) + $signed({2'b00, f5});
            tpsb_pkg::BLEND_SUB:     s = $signed({2'b00, b5}) - $signed({2'b00, f5});
            tpsb_pkg::BLEND_QUARTER: s = $signed({2'b00, b5}) + $signed({4'b0000, f5[4:2]});
            default:                 s = '0;
        endcase
        if (s < 0)
            result = 5'd0;
        else if (s > $signed(7'(tpsb_pkg::CHAN_MAX)))
            result = tpsb_pkg::CHAN_MAX;
        else
            result = s[4:0];
        return result;
    endfunction

    assign pop = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        fg_red   = shade_channel(item.texel[4:0], item.red, item.offset, item.ctrl);
        fg_green = shade_channel(item.texel[9:5], item.green, item.offset, item.ctrl);
        fg_blue  = shade_channel(item.texel[14:10], item.blue, item.offset, item.ctrl);
        fg_pixel = {fg_blue, fg_green, fg_red};
        blended  = {blend_channel(item.background[14:10], fg_blue, item.ctrl.semi_mode),
                    blend_channel(item.background[9:5], fg_green, item.ctrl.semi_mode),
                    blend_channel(item.background[4:0], fg_red, item.ctrl.semi_mode)};
        case (item.ctrl.kind)
            tpsb_pkg::KIND_TRANSPARENT:
            begin
                write_enable_next = 1'b0;
                pixel_value_next  = 16'd0;
            end
            tpsb_pkg::KIND_RAW:
            begin
                write_enable_next = 1'b1;
                pixel_value_next  = item.texel;
            end
            tpsb_pkg::KIND_SHADE:
            begin
                write_enable_next = 1'b1;
                pixel_value_next  = {item.ctrl.stp, item.ctrl.blend ? blended : fg_pixel};
            end
            default:
            begin
                write_enable_next = 1'b0;
                pixel_value_next  = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            write_enable_reg <= write_enable_next;
            pixel_value_reg  <= pixel_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = write_enable_reg;
    assign pixel_value  = pixel_value_reg;

    assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_valid_reg)
        else $error("loaded beat not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("output overwritten while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (item.ctrl.kind == tpsb_pkg::KIND_TRANSPARENT)) |=> !write_enable_reg)
        else $error("transparent texel written");

endmodule

// ===== rtl/textured_pixel_shade_blend.sv =====
// Channel   Handshake                Payload
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
// in        in_valid / in_stall      pixel_x_low, pixel_y_low, texel, color_*, background_pixel
// out       out_valid / out_stall    write_enable, pixel_value
//
// One pixel per cycle sustained while out_stall stays low; a pixel is written into the queue at
// its input beat and then popped into the output register once that register is free.
// The shading and blend datapath sits between queue and output register.
// Reset clears the mode registers to zero and empties the queue.
// in_stall rises only when the queue is full; cfg_ready is always high.
module textured_pixel_shade_blend
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tpsb_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [tpsb_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     pixel_x_low,
    input  logic [1:0]                     pixel_y_low,
    input  logic [15:0]                    texel,
    input  logic [7:0]                     color_red,
    input  logic [7:0]                     color_green,
    input  logic [7:0]                     color_blue,
    input  logic [15:0]                    background_pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           write_enable,
    output logic [15:0]                    pixel_value
);

    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    tpsb_pkg::item_t front_item;
    tpsb_pkg::item_t back_item;

    tpsb_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pixel_x_low      (pixel_x_low),
        .pixel_y_low      (pixel_y_low),
        .texel            (texel),
        .color_red        (color_red),
        .color_green      (color_green),
        .color_blue       (color_blue),
        .background_pixel (background_pixel),
        .queue_full       (queue_full),
        .push             (push),
        .item             (front_item)
    );

    tpsb_queue #(.Depth(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (back_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    tpsb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .item         (back_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_enable (write_enable),
        .pixel_value  (pixel_value)
    );

endmodule

// ===== bench/shade_blend_checker.sv =====
`timescale 1ns / 100ps

module shade_blend_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tpsb_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [tpsb_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     pixel_x_low,
    input  logic [1:0]                     pixel_y_low,
    input  logic [15:0]                    texel,
    input  logic [7:0]                     color_red,
    input  logic [7:0]                     color_green,
    input  logic [7:0]                     color_blue,
    input  logic [15:0]                    background_pixel,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           write_enable,
    input  logic [15:0]                    pixel_value,
    output int                             mismatch_count,
    output int                             awaiting_count,
    output int                             checked_count
);

    typedef struct packed {
        logic       textured;
        logic       raw;
        logic       semi;
        logic [1:0] blend;
        logic       dither;
        logic       gouraud;
    } draw_modes_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] pixel_value;
    } shaded_pixel_t;

    draw_modes_t   draw_mode;
    shaded_pixel_t expected_pixels [$];
    shaded_pixel_t head;
    int            errors;
    int            compared;
    int            dither_offset [16] = '{-4, 0, -3, 1, 2, -2, 3, -1, -3, 1, -4, 0, 3, -1, 2, -2};

    function automatic int clamp_range(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic shaded_pixel_t predict_pixel(
        input draw_modes_t m,
        input logic [1:0]  x_low,
        input logic [1:0]  y_low,
        input logic [15:0] tex,
        input logic [7:0]  red,
        input logic [7:0]  green,
        input logic [7:0]  blue,
        input logic [15:0] back
    );
        shaded_pixel_t res;
        int            offset;
        int            fore [3];
        int            tch [3];
        int            cch [3];
        int            bch;
        int            v;
        logic          blended;
        logic [14:0]   mixed;
        offset = dither_offset[{y_low, x_low}];
        cch[0] = red;
        cch[1] = green;
        cch[2] = blue;
        for (int c = 0; c < 3; c++)
        begin
            tch[c] = tex[c*5 +: 5];
        end
        res.write_enable = 1'b1;
        res.pixel_value  = tex;
        // transparent texel: no write, zero pixel
        if (m.textured && tex == 16'h0000)
        begin
            return '0;
        end
        if (m.textured && m.raw && !m.semi)
        begin
            return res;
        end
        for (int c = 0; c < 3; c++)
        begin
            if (!m.textured)
            begin
                if (m.dither && m.gouraud)
                    fore[c] = clamp_range(cch[c] + offset, 255) >> 3;
                else
                    fore[c] = cch[c] >> 3;
            end
            else if (m.raw)
                fore[c] = tch[c];
            else if (m.dither)
                fore[c] = clamp_range(clamp_range((tch[c] * cch[c]) >> 4, 255) + offset,
                                      255) >> 3;
            else
                fore[c] = clamp_range((tch[c] * cch[c]) >> 7, 31);
        end
        // textured pixels blend only when STP is set
        blended = m.semi && (!m.textured || tex[15]);
        for (int c = 0; c < 3; c++)
        begin
            bch = back[c*5 +: 5];
            v   = fore[c];
            if (blended)
            begin
                case (m.blend)
                    tpsb_pkg::BLEND_AVERAGE: v = (bch + fore[c]) >> 1;
                    tpsb_pkg::BLEND_ADD:     v = bch + fore[c];
                    tpsb_pkg::BLEND_SUB:     v = bch - fore[c];
                    default:                 v = bch + (fore[c] >> 2);
                endcase
            end
            mixed[c*5 +: 5] = 5'(clamp_range(v, 31));
        end
        res.pixel_value = {m.textured && tex[15], mixed};
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        errors++;
        if (errors <= 40)
            $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_mode <= '0;
            expected_pixels.delete();
            awaiting_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected beat", 16'h0000, pixel_value);
                else
                begin
                    head = expected_pixels.pop_front();
                    compared++;
                    if (write_enable !== head.write_enable)
                        report_mismatch("write_enable", 16'(head.write_enable), 16'(write_enable));
                    if (pixel_value !== head.pixel_value)
                        report_mismatch("pixel_value", head.pixel_value, pixel_value);
                end
            end
            if (in_valid && !in_stall)
                expected_pixels.push_back(predict_pixel(draw_mode, pixel_x_low, pixel_y_low, texel,
                                                        color_red, color_green, color_blue,
                                                        background_pixel));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tpsb_pkg::CFG_TEXTURED:       draw_mode.textured <= cfg_data[0];
                    tpsb_pkg::CFG_RAW_TEXTURE:    draw_mode.raw      <= cfg_data[0];
                    tpsb_pkg::CFG_SEMI_ENABLE:    draw_mode.semi     <= cfg_data[0];
                    tpsb_pkg::CFG_SEMI_MODE:      draw_mode.blend    <= cfg_data;
                    tpsb_pkg::CFG_DITHER_REQUEST: draw_mode.dither   <= cfg_data[0];
                    tpsb_pkg::CFG_GOURAUD_SHADED: draw_mode.gouraud  <= cfg_data[0];
                    default: ;
                endcase
            end
            awaiting_count <= expected_pixels.size();
            mismatch_count <= errors;
            checked_count  <= compared;
        end
    end

endmodule

// ===== bench/textured_pixel_shade_blend_tb.sv =====
`timescale 1ns / 100ps

module textured_pixel_shade_blend_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_PIXELS  = 50;
    localparam int HOLD_CYCLES   = 60;
    localparam logic [tpsb_pkg::CfgIndexW-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic [1:0]  x_low;
        logic [1:0]  y_low;
        logic [15:0] texel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] background;
    } pixel_beat_t;

    typedef struct packed {
        logic [tpsb_pkg::CfgDataW-1:0] textured;
        logic [tpsb_pkg::CfgDataW-1:0] raw;
        logic [tpsb_pkg::CfgDataW-1:0] semi;
        logic [tpsb_pkg::CfgDataW-1:0] blend;
        logic [tpsb_pkg::CfgDataW-1:0] dither;
        logic [tpsb_pkg::CfgDataW-1:0] gouraud;
    } mode_set_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tpsb_pkg::CfgIndexW-1:0] cfg_index;
    logic [tpsb_pkg::CfgDataW-1:0]  cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [1:0]                     pixel_x_low;
    logic [1:0]                     pixel_y_low;
    logic [15:0]                    texel;
    logic [7:0]                     color_red;
    logic [7:0]                     color_green;
    logic [7:0]                     color_blue;
    logic [15:0]                    background_pixel;
    logic                           out_valid;
    logic                           out_stall;
    logic                           write_enable;
    logic [15:0]                    pixel_value;

    int mismatch_count;
    int awaiting_count;
    int checked_count;
    int cycle_count;
    int settings_used;
    bit sender_eager;
    bit receiver_eager;
    bit long_hold_req;

    textured_pixel_shade_blend u_dut (.*);

    shade_blend_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("textured_pixel_shade_blend verification failed");
        $finish;
    end

    // output side: random stall runs, eager stretches and one long hold-off
    initial
    begin
        int   r;
        int   run;
        logic hold;
        bit   hold_taken;
        out_stall  = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (long_hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold = 1'b1;
                run  = HOLD_CYCLES;
            end
            else if (receiver_eager || r < 65)
            begin
                hold = 1'b0;
                run  = $urandom_range(1, 4);
            end
            else if (r < 95)
            begin
                hold = 1'b1;
                run  = $urandom_range(1, 3);
            end
            else
            begin
                hold = 1'b1;
                run  = $urandom_range(10, 30);
            end
            out_stall <= hold;
            repeat (run) @(posedge clk);
        end
    end

    function automatic mode_set_t modes(
        input logic [tpsb_pkg::CfgDataW-1:0] tex_on,
        input logic [tpsb_pkg::CfgDataW-1:0] raw_on,
        input logic [tpsb_pkg::CfgDataW-1:0] semi_on,
        input logic [tpsb_pkg::CfgDataW-1:0] blend,
        input logic [tpsb_pkg::CfgDataW-1:0] dither_on,
        input logic [tpsb_pkg::CfgDataW-1:0] gouraud_on
    );
        return '{tex_on, raw_on, semi_on, blend, dither_on, gouraud_on};
    endfunction

    function automatic pixel_beat_t make_pixel(
        input logic [1:0]  x_low,
        input logic [1:0]  y_low,
        input logic [15:0] tex,
        input logic [7:0]  red,
        input logic [7:0]  green,
        input logic [7:0]  blue,
        input logic [15:0] back
    );
        return '{x_low, y_low, tex, red, green, blue, back};
    endfunction

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        if (r < 16)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic pixel_beat_t random_pixel();
        pixel_beat_t p;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 10)
            p.texel = 16'h0000;
        else if (r < 15)
            p.texel = 16'h8000;
        else if (r < 25)
            p.texel = {1'($urandom), 15'h7FFF};
        else
            p.texel = 16'($urandom);
        p.x_low      = 2'($urandom);
        p.y_low      = 2'($urandom);
        p.red        = random_byte();
        p.green      = random_byte();
        p.blue       = random_byte();
        p.background = 16'($urandom);
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_eager)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic put_reg(input logic [tpsb_pkg::CfgIndexW-1:0] idx,
                           input logic [tpsb_pkg::CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_modes(input mode_set_t m);
        put_reg(tpsb_pkg::CFG_TEXTURED, m.textured);
        put_reg(tpsb_pkg::CFG_RAW_TEXTURE, m.raw);
        put_reg(tpsb_pkg::CFG_SEMI_ENABLE, m.semi);
        put_reg(tpsb_pkg::CFG_SEMI_MODE, m.blend);
        put_reg(tpsb_pkg::CFG_DITHER_REQUEST, m.dither);
        put_reg(tpsb_pkg::CFG_GOURAUD_SHADED, m.gouraud);
        put_reg(CFG_SPARE_INDEX, 2'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(input pixel_beat_t p);
        int gap;
        in_valid         <= 1'b1;
        pixel_x_low      <= p.x_low;
        pixel_y_low      <= p.y_low;
        texel            <= p.texel;
        color_red        <= p.red;
        color_green      <= p.green;
        color_blue       <= p.blue;
        background_pixel <= p.background;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_pixels();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting_count != 0);
    endtask

    initial
    begin
        mode_set_t  m;
        int         style;
        logic [1:0] blend_order [4];
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = tpsb_pkg::CFG_TEXTURED;
        cfg_data         = '0;
        in_valid         = 1'b0;
        pixel_x_low      = '0;
        pixel_y_low      = '0;
        texel            = '0;
        color_red        = '0;
        color_green      = '0;
        color_blue       = '0;
        background_pixel = '0;
        sender_eager     = 1'b0;
        receiver_eager   = 1'b0;
        long_hold_req    = 1'b0;
        settings_used    = 0;
        blend_order      = '{tpsb_pkg::BLEND_AVERAGE, tpsb_pkg::BLEND_ADD,
                             tpsb_pkg::BLEND_SUB, tpsb_pkg::BLEND_QUARTER};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // raw texels: transparent, opaque with and without STP
        apply_modes(modes(2'd1, 2'd1, 2'd0, tpsb_pkg::BLEND_AVERAGE, 2'd0, 2'd0));
        send_pixel(make_pixel(2'd0, 2'd0, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_pixel(make_pixel(2'd3, 2'd3, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_pixel(make_pixel(2'd1, 2'd2, 16'h7C1F, 8'h80, 8'h01, 8'hFE, 16'h8000));
        drain_pixels();

        // modulated and dithered texels, clamps at both ends
        apply_modes(modes(2'd1, 2'd0, 2'd0, tpsb_pkg::BLEND_AVERAGE, 2'd1, 2'd0));
        send_pixel(make_pixel(2'd0, 2'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000));
        send_pixel(make_pixel(2'd2, 2'd1, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_pixel(make_pixel(2'd1, 2'd0, 16'h8000, 8'hFF, 8'hFF, 8'hFF, 16'h1234));
        send_pixel(make_pixel(2'd3, 2'd2, 16'h0421, 8'h01, 8'h80, 8'hFF, 16'h7FFF));
        drain_pixels();

        // textured semi-transparency gated by STP
        apply_modes(modes(2'd1, 2'd0, 2'd1, tpsb_pkg::BLEND_ADD, 2'd0, 2'd0));
        send_pixel(make_pixel(2'd0, 2'd1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'h7FFF));
        send_pixel(make_pixel(2'd2, 2'd2, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 16'h7FFF));
        drain_pixels();

        apply_modes(modes(2'd1, 2'd1, 2'd1, tpsb_pkg::BLEND_SUB, 2'd0, 2'd0));
        send_pixel(make_pixel(2'd1, 2'd1, 16'h801F, 8'h00, 8'h00, 8'h00, 16'h0000));
        send_pixel(make_pixel(2'd3, 2'd0, 16'h03E0, 8'h00, 8'h00, 8'h00, 16'hFFFF));
        drain_pixels();

        // dither asked for but flat shading: no dither
        apply_modes(modes(2'd0, 2'd0, 2'd0, tpsb_pkg::BLEND_AVERAGE, 2'd1, 2'd0));
        send_pixel(make_pixel(2'd0, 2'd0, 16'h0000, 8'h07, 8'hF8, 8'h80, 16'h0000));
        drain_pixels();

        // flat color through every blend mode, dithered gouraud
        foreach (blend_order[k])
        begin
            apply_modes(modes(2'd0, 2'd0, 2'd1, blend_order[k], 2'd1, 2'd1));
            send_pixel(make_pixel(2'd0, 2'd0, 16'hFFFF, 8'h00, 8'h00, 8'h00, 16'hFFFF));
            send_pixel(make_pixel(2'd2, 2'd1, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 16'h0000));
            drain_pixels();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                m = modes(2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00);
            else if (ph == 1)
                m = modes(2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11);
            else
                m = modes(2'($urandom), 2'($urandom), 2'($urandom),
                          2'($urandom), 2'($urandom), 2'($urandom));
            apply_modes(m);
            style          = $urandom_range(0, 3);
            sender_eager   = style[0];
            receiver_eager = style[1];
            if (ph == 3)
            begin
                // hold the output while the sender keeps pushing
                long_hold_req = 1'b1;
                sender_eager  = 1'b1;
            end
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                send_pixel(random_pixel());
                if (ph == 5 && n == PHASE_PIXELS / 2)
                    drain_pixels();
            end
            drain_pixels();
        end
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;

        repeat (8) @(posedge clk);
        $display("checked %0d pixels across %0d draw mode settings", checked_count, settings_used);
        $display("covered transparent, raw, modulated, dithered and flat pixels, all blend modes");
        if (mismatch_count == 0)
            $display("textured_pixel_shade_blend verification clean");
        else
            $display("textured_pixel_shade_blend verification failed");
        $finish;
    end

endmodule

// ===== textured_pixel_shade_blend.f =====
rtl/tpsb_pkg.sv
rtl/tpsb_front.sv
rtl/tpsb_queue.sv
rtl/tpsb_back.sv
rtl/textured_pixel_shade_blend.sv
bench/shade_blend_checker.sv
bench/textured_pixel_shade_blend_tb.sv
